>>> hw/rtl/qalu_pkg.sv
package qalu_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_CONJ  = 3'd3,
        CMD_SCALE = 3'd4,
        CMD_ROT   = 3'd5
    } t_cmd;

    // load enables of the three register stages of one product pass
    typedef struct packed {
        logic mul;
        logic sum;
        logic sat;
    } t_pass_en;

endpackage

>>> hw/rtl/quaternion_alu.sv
// Fixed-point quaternion unit, signed values WORD_BITS wide with FRAC_BITS
// fraction bits.
// Input stream s_axis: one request per accepted beat, carrying an opcode
// (add, subtract, Hamilton product, conjugate, scale, rotate vector), two
// quaternions and a scalar. Output stream m_axis: one saturated quaternion
// and an overflow flag per request, in request order.
// Six register stages: two passes of multiply / sum / shift-and-clamp.
// Rotation uses both passes (b*v, then times conj(b)); product and scale
// take the first pass, add / subtract / conjugate are computed on entry and
// ride along through the first pass; all but rotate ride along through the second.
// Throughput: one request per clock while m_axis_tready does not stall.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled m_axis_tready holds results in place and bubbles close up;
// s_axis_tready drops only once all six stages hold work.
// Reset (synchronous, active low) empties the pipeline; nothing else is
// kept between requests.
module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 12,
    localparam int IN_BITS     = CMD_W + 9 * WORD_BITS,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = 4 * WORD_BITS + 1,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd, a_i, a_j, a_k, a_real, b_i, b_j, b_k, b_real, scale_factor
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // res_i, res_j, res_k, res_real, overflow
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int OPW         = WORD_BITS + 1;

    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [6:1] stg_rdy;
    logic [6:1] r_v;

    t_cmd                        in_cmd;
    logic signed [WORD_BITS-1:0] in_a [4];
    logic signed [WORD_BITS-1:0] in_b [4];
    logic signed [WORD_BITS-1:0] in_s;

    logic signed [OPW-1:0]       as_full [4];
    logic signed [WORD_BITS-1:0] n_as [4];
    logic                        n_asovf;

    t_pass_en              p1_en;
    t_pass_en              p2_en;
    logic                  p1_scale;
    logic signed [OPW-1:0] p1_l [4];
    logic signed [OPW-1:0] p1_r [4];
    logic signed [OPW-1:0] p2_l [4];
    logic signed [OPW-1:0] p2_r [4];
    logic signed [WORD_BITS-1:0] p1_q [4];
    logic signed [WORD_BITS-1:0] p2_q [4];
    logic [3:0]                  p1_ovf;
    logic [3:0]                  p2_ovf;

    // side data of stages 1..3
    t_cmd                        r_cmd1, r_cmd2, r_cmd3;
    logic signed [WORD_BITS-1:0] r_as1 [4];
    logic signed [WORD_BITS-1:0] r_as2 [4];
    logic signed [WORD_BITS-1:0] r_as3 [4];
    logic                        r_asovf1, r_asovf2, r_asovf3;
    logic signed [WORD_BITS-1:0] r_b1 [4];
    logic signed [WORD_BITS-1:0] r_b2 [4];
    logic signed [WORD_BITS-1:0] r_b3 [4];

    // side data of stages 4..6
    logic signed [WORD_BITS-1:0] n_w4 [4];
    logic                        n_ovf4;
    logic signed [WORD_BITS-1:0] r_w4 [4];
    logic signed [WORD_BITS-1:0] r_w5 [4];
    logic signed [WORD_BITS-1:0] r_w6 [4];
    logic                        r_ovf4, r_ovf5, r_ovf6;
    logic                        r_rot4, r_rot5, r_rot6;

    // stage handshake: a stage loads when empty or when its successor loads
    always_comb begin
        stg_rdy[6] = !r_v[6] || m_axis_tready;
        for (int k = 5; k >= 1; k--) begin
            stg_rdy[k] = !r_v[k] || stg_rdy[k+1];
        end
    end

    assign s_axis_tready = stg_rdy[1];
    assign m_axis_tvalid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_rdy[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (stg_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // request fields
    always_comb begin
        in_cmd = t_cmd'(s_axis_tdata[CMD_W-1:0]);
        for (int n = 0; n < 4; n++) begin
            in_a[n] = s_axis_tdata[CMD_W + n*WORD_BITS +: WORD_BITS];
            in_b[n] = s_axis_tdata[CMD_W + (4+n)*WORD_BITS +: WORD_BITS];
        end
        in_s = s_axis_tdata[CMD_W + 8*WORD_BITS +: WORD_BITS];
    end

    // add / subtract / conjugate: one extra bit, then clamp
    always_comb begin
        n_asovf = 1'b0;
        for (int n = 0; n < 4; n++) begin
            case (in_cmd)
                CMD_SUB:  as_full[n] = {in_a[n][WORD_BITS-1], in_a[n]}
                                     - {in_b[n][WORD_BITS-1], in_b[n]};
                CMD_CONJ: as_full[n] = (n == 3) ? {in_a[n][WORD_BITS-1], in_a[n]}
                                     : -{in_a[n][WORD_BITS-1], in_a[n]};
                default:  as_full[n] = {in_a[n][WORD_BITS-1], in_a[n]}
                                     + {in_b[n][WORD_BITS-1], in_b[n]};
            endcase
            if (as_full[n][WORD_BITS] != as_full[n][WORD_BITS-1]) begin
                n_as[n] = as_full[n][WORD_BITS] ? W_MIN : W_MAX;
                n_asovf = 1'b1;
            end else begin
                n_as[n] = as_full[n][WORD_BITS-1:0];
            end
        end
    end

    // first pass operands: a*b, b*v with zero real part, or a times scalar
    always_comb begin
        p1_scale = (in_cmd == CMD_SCALE);
        for (int n = 0; n < 4; n++) begin
            case (in_cmd)
                CMD_ROT: begin
                    p1_l[n] = {in_b[n][WORD_BITS-1], in_b[n]};
                    p1_r[n] = (n == 3) ? '0 : {in_a[n][WORD_BITS-1], in_a[n]};
                end
                CMD_SCALE: begin
                    p1_l[n] = {in_a[n][WORD_BITS-1], in_a[n]};
                    p1_r[n] = {in_s[WORD_BITS-1], in_s};
                end
                default: begin
                    p1_l[n] = {in_a[n][WORD_BITS-1], in_a[n]};
                    p1_r[n] = {in_b[n][WORD_BITS-1], in_b[n]};
                end
            endcase
        end
    end

    assign p1_en.mul = stg_rdy[1];
    assign p1_en.sum = stg_rdy[2];
    assign p1_en.sat = stg_rdy[3];
    assign p2_en.mul = stg_rdy[4];
    assign p2_en.sum = stg_rdy[5];
    assign p2_en.sat = stg_rdy[6];

    qalu_hpass #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pass1 (
        .i_clk   (i_clk),
        .i_en    (p1_en),
        .i_scale (p1_scale),
        .i_l     (p1_l),
        .i_r     (p1_r),
        .o_q     (p1_q),
        .o_ovf   (p1_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_cmd1   <= in_cmd;
            r_asovf1 <= n_asovf;
            for (int n = 0; n < 4; n++) begin
                r_as1[n] <= n_as[n];
                r_b1[n]  <= in_b[n];
            end
        end
        if (stg_rdy[2]) begin
            r_cmd2   <= r_cmd1;
            r_asovf2 <= r_asovf1;
            for (int n = 0; n < 4; n++) begin
                r_as2[n] <= r_as1[n];
                r_b2[n]  <= r_b1[n];
            end
        end
        if (stg_rdy[3]) begin
            r_cmd3   <= r_cmd2;
            r_asovf3 <= r_asovf2;
            for (int n = 0; n < 4; n++) begin
                r_as3[n] <= r_as2[n];
                r_b3[n]  <= r_b2[n];
            end
        end
    end

    // second pass: clamped b*v times conj(b), conj kept at full precision
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            p2_l[n] = {p1_q[n][WORD_BITS-1], p1_q[n]};
            p2_r[n] = (n == 3) ? {r_b3[n][WORD_BITS-1], r_b3[n]}
                    : -{r_b3[n][WORD_BITS-1], r_b3[n]};
        end
    end

    qalu_hpass #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pass2 (
        .i_clk   (i_clk),
        .i_en    (p2_en),
        .i_scale (1'b0),
        .i_l     (p2_l),
        .i_r     (p2_r),
        .o_q     (p2_q),
        .o_ovf   (p2_ovf)
    );

    // result of everything but rotate is settled after the first pass
    always_comb begin
        n_ovf4 = 1'b0;
        for (int n = 0; n < 4; n++) begin
            n_w4[n] = '0;
        end
        case (r_cmd3)
            CMD_ADD, CMD_SUB, CMD_CONJ: begin
                n_ovf4 = r_asovf3;
                for (int n = 0; n < 4; n++) begin
                    n_w4[n] = r_as3[n];
                end
            end
            CMD_MUL, CMD_SCALE, CMD_ROT: begin
                n_ovf4 = |p1_ovf;
                for (int n = 0; n < 4; n++) begin
                    n_w4[n] = p1_q[n];
                end
            end
            default: begin
                n_ovf4 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r_rot4 <= (r_cmd3 == CMD_ROT);
            r_ovf4 <= n_ovf4;
            for (int n = 0; n < 4; n++) begin
                r_w4[n] <= n_w4[n];
            end
        end
        if (stg_rdy[5]) begin
            r_rot5 <= r_rot4;
            r_ovf5 <= r_ovf4;
            for (int n = 0; n < 4; n++) begin
                r_w5[n] <= r_w4[n];
            end
        end
        if (stg_rdy[6]) begin
            r_rot6 <= r_rot5;
            r_ovf6 <= r_ovf5;
            for (int n = 0; n < 4; n++) begin
                r_w6[n] <= r_w5[n];
            end
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int n = 0; n < 4; n++) begin
            m_axis_tdata[n*WORD_BITS +: WORD_BITS] = r_rot6 ? p2_q[n] : r_w6[n];
        end
        m_axis_tdata[4*WORD_BITS] = r_ovf6 || (r_rot6 && (|p2_ovf));
    end

endmodule

>>> hw/rtl/qalu_hpass.sv
module qalu_hpass
    import qalu_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic                        i_clk,
    input  t_pass_en                    i_en,
    input  logic                        i_scale,
    input  logic signed [WORD_BITS:0]   i_l [4],
    input  logic signed [WORD_BITS:0]   i_r [4],
    output logic signed [WORD_BITS-1:0] o_q [4],
    output logic [3:0]                  o_ovf
);

    localparam int OPW  = WORD_BITS + 1;
    localparam int PW   = 2 * OPW;
    localparam int SUMW = PW + 2;

    localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-WORD_BITS+1){1'b0}},
                                                 {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-WORD_BITS+1){1'b1}},
                                                 {(WORD_BITS-1){1'b0}}};

    logic signed [PW-1:0]        n_p   [4][4];
    logic signed [PW-1:0]        r_p   [4][4];
    logic                        r_scale;
    logic signed [SUMW-1:0]      n_sum [4];
    logic signed [SUMW-1:0]      r_sum [4];
    logic signed [SUMW-1:0]      n_sh  [4];
    logic signed [WORD_BITS-1:0] n_q   [4];
    logic signed [WORD_BITS-1:0] r_q   [4];
    logic [3:0]                  n_ovf;
    logic [3:0]                  r_ovf;

    function automatic logic signed [SUMW-1:0] ext(input logic signed [PW-1:0] x);
        return {{(SUMW-PW){x[PW-1]}}, x};
    endfunction

    // all sixteen cross products l[m]*r[n]
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            for (int n = 0; n < 4; n++) begin
                n_p[m][n] = i_l[m] * i_r[n];
            end
        end
    end

    always_comb begin
        if (r_scale) begin
            for (int n = 0; n < 4; n++) begin
                n_sum[n] = ext(r_p[n][0]);
            end
        end else begin
            n_sum[0] = ext(r_p[0][3]) + ext(r_p[3][0]) + ext(r_p[1][2]) - ext(r_p[2][1]);
            n_sum[1] = ext(r_p[3][1]) - ext(r_p[0][2]) + ext(r_p[1][3]) + ext(r_p[2][0]);
            n_sum[2] = ext(r_p[3][2]) + ext(r_p[0][1]) - ext(r_p[1][0]) + ext(r_p[2][3]);
            n_sum[3] = ext(r_p[3][3]) - ext(r_p[0][0]) - ext(r_p[1][1]) - ext(r_p[2][2]);
        end
    end

    // floor shift, then clamp to the word range
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            n_sh[n] = r_sum[n] >>> FRAC_BITS;
            if (n_sh[n] > SAT_HI) begin
                n_q[n]   = SAT_HI[WORD_BITS-1:0];
                n_ovf[n] = 1'b1;
            end else if (n_sh[n] < SAT_LO) begin
                n_q[n]   = SAT_LO[WORD_BITS-1:0];
                n_ovf[n] = 1'b1;
            end else begin
                n_q[n]   = n_sh[n][WORD_BITS-1:0];
                n_ovf[n] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_scale <= i_scale;
            for (int m = 0; m < 4; m++) begin
                for (int n = 0; n < 4; n++) begin
                    r_p[m][n] <= n_p[m][n];
                end
            end
        end
        if (i_en.sum) begin
            for (int n = 0; n < 4; n++) begin
                r_sum[n] <= n_sum[n];
            end
        end
        if (i_en.sat) begin
            r_ovf <= n_ovf;
            for (int n = 0; n < 4; n++) begin
                r_q[n] <= n_q[n];
            end
        end
    end

    assign o_q   = r_q;
    assign o_ovf = r_ovf;

endmodule
